[sv/upd_pkg.sv]
// ----------------------------------------------------------------------------
// upd_pkg: shared types and constants for the URI percent decoder
// Decoder state codes, status codes, the result word layout and hex lookup.
// ----------------------------------------------------------------------------
package upd_pkg;

    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_SKIP    = 5'b00010,
        MODE_HEX1    = 5'b00100,
        MODE_HEX2    = 5'b01000,
        MODE_DISCARD = 5'b10000
    } mode_t;

    typedef logic [1:0] status_t;

    localparam status_t ST_DATA  = 2'd0;
    localparam status_t ST_BAD   = 2'd1;
    localparam status_t ST_TRUNC = 2'd2;

    localparam logic [7:0] CH_PERCENT   = 8'h25;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_0         = 8'h30;
    localparam logic [7:0] CH_9         = 8'h39;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] HEX_TEN      = 8'd10;

    typedef struct packed {
        logic [7:0] data;
        status_t    status;
        logic       last;
    } result_t;

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [7:0] v;
        v = 8'd0;
        if (b >= CH_0 && b <= CH_9) begin
            v = b - CH_0;
            return {1'b0, v[3:0]};
        end
        if (b >= CH_UA && b <= CH_UF) begin
            v = b - CH_UA + HEX_TEN;
            return {1'b0, v[3:0]};
        end
        if (b >= CH_LA && b <= CH_LF) begin
            v = b - CH_LA + HEX_TEN;
            return {1'b0, v[3:0]};
        end
        return 5'b10000;
    endfunction

endpackage

[sv/upd_in_stage.sv]
// ----------------------------------------------------------------------------
// upd_in_stage: input register
// Captures one input word; holds it until the decode stage takes it.
// ----------------------------------------------------------------------------
module upd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    input  logic       advance,
    output logic       s1_valid,
    output logic [7:0] s1_byte,
    output logic       s1_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       load;

    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load || advance)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_byte  = byte_reg;
    assign s1_last  = last_reg;

endmodule

[sv/upd_core.sv]
// ----------------------------------------------------------------------------
// upd_core: escape decode state machine
// Holds the decode mode and high nibble, and forms at most one result per word.
// ----------------------------------------------------------------------------
module upd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic [7:0]      s1_byte,
    input  logic            s1_last,
    output logic            produce,
    output upd_pkg::result_t res
);
    import upd_pkg::*;

    mode_t      mode_reg, mode_next;
    logic [3:0] nib_reg, nib_next;
    logic [4:0] hv;

    assign hv = hex_value(s1_byte);

    always_comb
    begin
        mode_next = mode_reg;
        nib_next  = nib_reg;
        produce   = 1'b0;
        res       = '{data: 8'd0, status: ST_DATA, last: 1'b1};
        unique case (mode_reg)
            MODE_SKIP:
            begin
                if (s1_last)
                begin
                    produce    = 1'b1;
                    res.status = ST_TRUNC;
                end
                else
                begin
                    mode_next = MODE_HEX1;
                end
            end
            MODE_HEX1:
            begin
                if (hv[4])
                begin
                    produce    = 1'b1;
                    res.status = ST_BAD;
                    mode_next  = MODE_DISCARD;
                end
                else if (s1_last)
                begin
                    produce    = 1'b1;
                    res.status = ST_TRUNC;
                end
                else
                begin
                    nib_next  = hv[3:0];
                    mode_next = MODE_HEX2;
                end
            end
            MODE_HEX2:
            begin
                produce = 1'b1;
                if (hv[4])
                begin
                    res.status = ST_BAD;
                    mode_next  = MODE_DISCARD;
                end
                else
                begin
                    res.data  = {nib_reg, hv[3:0]};
                    res.last  = s1_last;
                    mode_next = MODE_IDLE;
                end
                nib_next = 4'd0;
            end
            MODE_DISCARD:
            begin
                produce = 1'b0;
            end
            default:
            begin
                if (s1_byte == CH_PERCENT || s1_byte == CH_BACKSLASH)
                begin
                    if (s1_last)
                    begin
                        produce    = 1'b1;
                        res.status = ST_TRUNC;
                    end
                    else
                    begin
                        mode_next = (s1_byte == CH_PERCENT) ? MODE_HEX1 : MODE_SKIP;
                    end
                end
                else
                begin
                    produce   = 1'b1;
                    res.data  = s1_byte;
                    res.last  = s1_last;
                    mode_next = MODE_IDLE;
                end
            end
        endcase
        // final byte always closes the string
        if (s1_last)
        begin
            mode_next = MODE_IDLE;
            nib_next  = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            nib_reg  <= 4'd0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            nib_reg  <= nib_next;
        end
    end

endmodule

[sv/uri_percent_decoder_top.sv]
// An accepted input word passes the input register, then the result register.
// Throughput: one word per cycle; the input register feeds the decode logic
// and a result register, both advancing whenever the result slot is free.
// Words that cause no result (escape lead-ins, discarded bytes) take an input slot too.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// decoder to idle with the high nibble cleared.
// ----------------------------------------------------------------------------
// uri_percent_decoder_top: streaming URI percent-escape decoder
// Input register, escape decode state machine, registered result word.
// ----------------------------------------------------------------------------
module uri_percent_decoder_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [7:0]       out_byte,
    output upd_pkg::status_t status,
    output logic             out_end
);
    import upd_pkg::*;

    logic       s1_valid;
    logic [7:0] s1_byte;
    logic       s1_last;
    logic       out_free;
    logic       advance;
    logic       produce;
    result_t    res;
    logic       out_valid_reg;
    result_t    out_reg;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid && out_free;

    upd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .advance  (advance),
        .s1_valid (s1_valid),
        .s1_byte  (s1_byte),
        .s1_last  (s1_last)
    );

    upd_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (advance),
        .s1_byte (s1_byte),
        .s1_last (s1_last),
        .produce (produce),
        .res     (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && produce;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_reg.data;
    assign status    = out_reg.status;
    assign out_end   = out_reg.last;

endmodule

[sv/upd_checker.sv]
// ----------------------------------------------------------------------------
// upd_checker: port-level checks for the URI percent decoder
// Watches the result channel; bound to the top level below.
// ----------------------------------------------------------------------------
module upd_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [7:0]       out_byte,
    input upd_pkg::status_t status,
    input logic             out_end
);
    import upd_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(status)
            && $stable(out_end))
        else $error("result word changed while stalled");

    // errors always close the string
    a_err_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DATA |-> out_end)
        else $error("error word without end mark");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DATA |-> out_byte == 8'd0)
        else $error("error word carries data");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == ST_DATA || status == ST_BAD || status == ST_TRUNC)
        else $error("unknown status code");

endmodule

bind uri_percent_decoder_top upd_checker u_upd_checker (.*);

[tb/tb_uri_percent_decoder_top.sv]
// ----------------------------------------------------------------------------
// tb_uri_percent_decoder_top: self-checking bench for the URI percent decoder
// Directed strings cover plain bytes, both escape forms, escapes cut short by
// the end flag and bad hex digits. Random strings follow: mostly well-formed
// text with escapes, plus noise and strings cut in the middle. A local decoder
// model predicts each result word, and the checker compares every field.
// ----------------------------------------------------------------------------
module tb_uri_percent_decoder_top;

    import upd_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 1875;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] in_byte   = 8'h00;
    logic       in_last   = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] out_byte;
    status_t    status;
    logic       out_end;

    // decoder model state
    mode_t      model_mode   = MODE_IDLE;
    logic [3:0] model_nibble = 4'h0;
    result_t    pending_decodes[$];

    int         mismatch_count   = 0;
    int         unexpected_count = 0;
    int         idle_cycles      = 0;
    int         sink_hold        = 0;
    bit         quiet_tail       = 1'b0;
    result_t    want;

    uri_percent_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .status    (status),
        .out_end   (out_end)
    );

    always #1 clk = ~clk;

    // bit 4 set: not a hex digit
    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CH_0 && c <= CH_9)
        begin
            return {1'b0, c[3:0]};
        end
        if (folded >= CH_LA && folded <= CH_LF)
        begin
            return {1'b0, 4'(folded - CH_LA + HEX_TEN)};
        end
        return 5'h10;
    endfunction

    function automatic void push_decode(input logic [7:0] d, input status_t st,
                                        input logic e);
        result_t r;
        r.data   = d;
        r.status = st;
        r.last   = e;
        pending_decodes.push_back(r);
    endfunction

    // advance the model by one accepted word
    function automatic void decode_step(input logic [7:0] b, input logic l);
        logic [4:0] nib;
        nib = nibble_of(b);
        case (model_mode)
            MODE_SKIP:
            begin
                if (l)
                    push_decode(8'h00, ST_TRUNC, 1'b1);
                else
                    model_mode = MODE_HEX1;
            end
            MODE_HEX1:
            begin
                if (nib[4])
                begin
                    push_decode(8'h00, ST_BAD, 1'b1);
                    model_mode = MODE_DISCARD;
                end
                else if (l)
                    push_decode(8'h00, ST_TRUNC, 1'b1);
                else
                begin
                    model_nibble = nib[3:0];
                    model_mode   = MODE_HEX2;
                end
            end
            MODE_HEX2:
            begin
                if (nib[4])
                begin
                    push_decode(8'h00, ST_BAD, 1'b1);
                    model_mode = MODE_DISCARD;
                end
                else
                begin
                    push_decode({model_nibble, nib[3:0]}, ST_DATA, l);
                    model_mode = MODE_IDLE;
                end
                model_nibble = 4'h0;
            end
            MODE_DISCARD:
            begin
            end
            default:
            begin
                if (b == CH_PERCENT || b == CH_BACKSLASH)
                begin
                    if (l)
                        push_decode(8'h00, ST_TRUNC, 1'b1);
                    else
                        model_mode = (b == CH_PERCENT) ? MODE_HEX1 : MODE_SKIP;
                end
                else
                begin
                    push_decode(b, ST_DATA, l);
                    model_mode = MODE_IDLE;
                end
            end
        endcase
        if (l)
        begin
            model_mode   = MODE_IDLE;
            model_nibble = 4'h0;
        end
    endfunction

    // valid stays high into the next word unless a gap is taken
    task automatic send_word(input logic [7:0] b, input logic l);
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        decode_step(b, l);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    function automatic logic [7:0] random_hex_char();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10)
            return CH_0 + 8'(r);
        if (r < 16)
            return CH_LA + 8'(r - 10);
        return CH_UA + 8'(r - 16);
    endfunction

    task automatic test_plain_bytes();
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h41, 1'b1);
    endtask

    task automatic test_escape_forms();
        send_word(CH_PERCENT, 1'b0);
        send_word("4", 1'b0);
        send_word("a", 1'b0);
        send_word(CH_BACKSLASH, 1'b0);
        send_word("x", 1'b0);
        send_word("7", 1'b0);
        send_word("F", 1'b1);
    endtask

    task automatic test_cut_escapes();
        send_word(CH_PERCENT, 1'b1);
        send_word(CH_BACKSLASH, 1'b1);
        send_word(CH_BACKSLASH, 1'b0);
        send_word("x", 1'b1);
        send_word(CH_PERCENT, 1'b0);
        send_word("a", 1'b1);
    endtask

    task automatic test_bad_digits();
        // bad first digit, then the rest of the string is dropped
        send_word(CH_PERCENT, 1'b0);
        send_word("g", 1'b0);
        send_word("z", 1'b0);
        send_word(CH_PERCENT, 1'b1);
        // bad digit on the final word wins over the cut-short check
        send_word(CH_PERCENT, 1'b0);
        send_word("1", 1'b0);
        send_word("G", 1'b1);
        send_word(CH_PERCENT, 1'b0);
        send_word("/", 1'b1);
    endtask

    task automatic test_random_strings(input int target);
        logic [7:0] text[$];
        logic [7:0] c;
        int         sent;
        int         pick;
        int         cut;
        sent = 0;
        while (sent < target)
        begin
            text.delete();
            repeat ($urandom_range(1, 8))
            begin
                pick = $urandom_range(0, 19);
                if (pick <= 10)
                begin
                    c = 8'($urandom);
                    if (c == CH_PERCENT || c == CH_BACKSLASH)
                        c = c ^ 8'h01;
                    text.push_back(c);
                end
                else if (pick <= 15)
                begin
                    text.push_back(CH_PERCENT);
                    text.push_back(random_hex_char());
                    text.push_back(random_hex_char());
                end
                else if (pick <= 17)
                begin
                    text.push_back(CH_BACKSLASH);
                    text.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h78);
                    text.push_back(random_hex_char());
                    text.push_back(random_hex_char());
                end
                else if (pick == 18)
                    text.push_back(8'($urandom));
                else
                begin
                    text.push_back(CH_PERCENT);
                    text.push_back(8'($urandom));
                    text.push_back(8'($urandom));
                end
            end
            // some strings are cut short at a random length, which may end inside an escape
            if (text.size() > 1 && $urandom_range(0, 5) == 0)
            begin
                cut = $urandom_range(1, text.size() - 1);
                while (text.size() > cut)
                    void'(text.pop_back());
            end
            for (int i = 0; i < text.size(); i++)
            begin
                if (sent >= target * 17 / 20)
                    quiet_tail = 1'b1;
                send_word(text[i], i == text.size() - 1);
                sent++;
            end
        end
    endtask

    // result side stalls in randomly started bursts; never in reset or the quiet tail
    always @(posedge clk)
    begin
        if (!rst_n || quiet_tail)
            out_stall <= 1'b0;
        else if (sink_hold != 0)
        begin
            out_stall <= 1'b1;
            sink_hold <= sink_hold - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            out_stall <= 1'b1;
            sink_hold <= $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_decodes.size() == 0)
            begin
                if (mismatch_count + unexpected_count < 10)
                    $display("unexpected word: byte=%h status=%0d end=%b",
                             out_byte, status, out_end);
                unexpected_count++;
            end
            else
            begin
                want = pending_decodes.pop_front();
                if (out_byte !== want.data || status !== want.status ||
                    out_end !== want.last)
                begin
                    if (mismatch_count + unexpected_count < 10)
                        $display("mismatch: byte=%h/%h status=%0d/%0d end=%b/%b",
                                 want.data, out_byte, want.status, status,
                                 want.last, out_end);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_bytes();
        test_escape_forms();
        test_cut_escapes();
        test_bad_digits();
        test_random_strings(RANDOM_WORDS);
        in_valid <= 1'b0;
        while (pending_decodes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && unexpected_count == 0 && pending_decodes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[filelist.f]
sv/upd_pkg.sv
sv/upd_in_stage.sv
sv/upd_core.sv
sv/uri_percent_decoder_top.sv
sv/upd_checker.sv
tb/tb_uri_percent_decoder_top.sv
